/* hdl/bdq_pkg.sv */
package bdq_pkg;

    // Default list depth and the longest dump reported.
    localparam int CAPACITY_DEF = 32;
    localparam int DUMP_LIMIT   = 32;

    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_POP_HEAD  = 3'd3,
        OP_POP_TAIL  = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_DUMP_FWD  = 3'd6,
        OP_DUMP_BACK = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH,
        S_POP,
        S_DUMP,
        S_EMIT
    } state_t;

    // Write enables into the node store.
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } bdq_wr_t;

endpackage

/* hdl/bdq_store.sv */
module bdq_store #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic                 aclk,
    input  bdq_pkg::bdq_wr_t     wr_en,
    input  logic [IW-1:0]        val_waddr,
    input  logic signed [31:0]   val_wdata,
    input  logic [IW-1:0]        nxt_waddr,
    input  logic [IW-1:0]        nxt_wdata,
    input  logic [IW-1:0]        prv_waddr,
    input  logic [IW-1:0]        prv_wdata,
    input  logic [IW-1:0]        rd_addr,
    output logic signed [31:0]   rd_val,
    output logic [IW-1:0]        rd_nxt,
    output logic [IW-1:0]        rd_prv
);
    import bdq_pkg::*;

    logic signed [31:0] val_mem [CAPACITY];
    logic [IW-1:0]      nxt_mem [CAPACITY];
    logic [IW-1:0]      prv_mem [CAPACITY];

    logic signed [31:0] rd_val_reg;
    logic [IW-1:0]      rd_nxt_reg;
    logic [IW-1:0]      rd_prv_reg;

    // Node values and both link directions share one read address
    always_ff @(posedge aclk) begin
        if (wr_en.val) begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (wr_en.nxt) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (wr_en.prv) begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        rd_val_reg <= val_mem[rd_addr];
        rd_nxt_reg <= nxt_mem[rd_addr];
        rd_prv_reg <= prv_mem[rd_addr];
    end

    assign rd_val = rd_val_reg;
    assign rd_nxt = rd_nxt_reg;
    assign rd_prv = rd_prv_reg;

endmodule

/* hdl/bounded_deque_with_value_remove_unit.sv */
// Push and clear go from decode to emit; pop passes through the pop state; remove walks
// the nodes in the search state. Dumps deliver one entry per cycle unless m_ready stalls them,
// after decode, limited by the node store read port. One request at a time (s_ready in idle).
// Reset: synchronous, active low; list empty, no clearing pass (slots above a fill
// count are free, freed slots form a linked stack).
module bounded_deque_with_value_remove_unit #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_value,
    output logic [5:0]         m_entry_count,
    output logic [1:0]         m_status,
    output logic               m_value_valid,
    output logic               m_last_of_run
);
    import bdq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;

    opcode_t            op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      hw_reg, hw_next;
    logic [IW-1:0]      fs_head_reg, fs_head_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      idx_reg, idx_next;

    logic signed [31:0] res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic               res_valid_reg, res_valid_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [5:0]         out_count_reg, out_count_next;
    status_t            out_status_reg, out_status_next;
    logic               out_vv_reg, out_vv_next;
    logic               out_last_reg, out_last_next;

    // Node store ports
    bdq_wr_t            wr_en;
    logic [IW-1:0]      val_waddr, nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, rd_addr;
    logic signed [31:0] rd_val;
    logic [IW-1:0]      rd_nxt, rd_prv;

    // Free stack links
    logic [IW-1:0]      free_mem [CAPACITY];
    logic [IW-1:0]      free_rd_reg;
    logic               free_we;

    logic               out_free, is_push, empty, found, srch_end, dump_last;
    logic [CW-1:0]      idx_inc;

    bdq_store #(.CAPACITY(CAPACITY), .IW(IW)) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .val_waddr (val_waddr),
        .val_wdata (val_reg),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .prv_waddr (prv_waddr),
        .prv_wdata (prv_wdata),
        .rd_addr   (rd_addr),
        .rd_val    (rd_val),
        .rd_nxt    (rd_nxt),
        .rd_prv    (rd_prv)
    );

    // Free stack: push on release, read of the top always ready
    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[ptr_reg] <= fs_head_reg;
        end
        free_rd_reg <= free_mem[fs_head_reg];
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign is_push   = (op_reg == OP_PUSH_TAIL) || (op_reg == OP_PUSH_HEAD);
    assign empty     = (count_reg == '0);
    assign found     = (rd_val == val_reg);
    assign idx_inc   = idx_reg + 1'b1;
    assign srch_end  = (idx_inc == count_reg);
    assign dump_last = (idx_inc == count_reg) || (32'(idx_inc) == 32'(DUMP_LIMIT));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (op_reg)
                    OP_REMOVE:                state_next = empty ? S_EMIT : S_SRCH;
                    OP_POP_HEAD, OP_POP_TAIL: state_next = empty ? S_EMIT : S_POP;
                    OP_DUMP_FWD, OP_DUMP_BACK: state_next = empty ? S_EMIT : S_DUMP;
                    default:                  state_next = S_EMIT;
                endcase
            end
            S_SRCH: begin
                if (found || srch_end) state_next = S_EMIT;
            end
            S_POP: begin
                state_next = S_EMIT;
            end
            S_DUMP: begin
                if (out_free && dump_last) state_next = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        logic [IW-1:0] slot;
        logic          do_unlink;
        logic          out_load;

        op_next         = op_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        fs_head_next    = fs_head_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_vv_next     = out_vv_reg;
        out_last_next   = out_last_reg;
        wr_en           = '0;
        val_waddr       = '0;
        nxt_waddr       = '0;
        nxt_wdata       = '0;
        prv_waddr       = '0;
        prv_wdata       = '0;
        rd_addr         = ptr_reg;
        free_we         = 1'b0;
        slot            = '0;
        do_unlink       = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = opcode_t'(s_opcode);
                    val_next = s_item_value;
                end
            end
            S_DECODE: begin
                res_value_next  = '0;
                res_valid_next  = 1'b0;
                res_status_next = ST_OK;
                idx_next        = '0;
                if (is_push) begin
                    if (count_reg >= CW'(CAPACITY)) begin
                        res_status_next = ST_FULL;
                    end else begin
                        // reuse a freed slot first, else the next never-used one
                        if (hw_reg > count_reg) begin
                            slot         = fs_head_reg;
                            fs_head_next = free_rd_reg;
                        end else begin
                            slot    = hw_reg[IW-1:0];
                            hw_next = hw_reg + 1'b1;
                        end
                        wr_en.val = 1'b1;
                        val_waddr = slot;
                        if (empty) begin
                            head_next = slot;
                            tail_next = slot;
                        end else if (op_reg == OP_PUSH_TAIL) begin
                            wr_en.prv = 1'b1;
                            prv_waddr = slot;
                            prv_wdata = tail_reg;
                            wr_en.nxt = 1'b1;
                            nxt_waddr = tail_reg;
                            nxt_wdata = slot;
                            tail_next = slot;
                        end else begin
                            wr_en.nxt = 1'b1;
                            nxt_waddr = slot;
                            nxt_wdata = head_reg;
                            wr_en.prv = 1'b1;
                            prv_waddr = head_reg;
                            prv_wdata = slot;
                            head_next = slot;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end else if (op_reg == OP_CLEAR) begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    hw_next    = '0;
                end else if (empty) begin
                    if (op_reg == OP_REMOVE || op_reg == OP_POP_HEAD ||
                        op_reg == OP_POP_TAIL) begin
                        res_status_next = ST_EMPTY;
                    end
                end else begin
                    // start the walk at head or tail
                    if (op_reg == OP_POP_TAIL || op_reg == OP_DUMP_BACK) begin
                        ptr_next = tail_reg;
                        rd_addr  = tail_reg;
                    end else begin
                        ptr_next = head_reg;
                        rd_addr  = head_reg;
                    end
                end
            end
            S_SRCH: begin
                if (found) begin
                    do_unlink = 1'b1;
                end else if (srch_end) begin
                    res_status_next = ST_NOTFOUND;
                end else begin
                    ptr_next = rd_nxt;
                    rd_addr  = rd_nxt;
                    idx_next = idx_inc;
                end
            end
            S_POP: begin
                res_value_next = rd_val;
                res_valid_next = 1'b1;
                do_unlink      = 1'b1;
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_value_next  = rd_val;
                    out_status_next = ST_OK;
                    out_vv_next     = 1'b1;
                    out_last_next   = dump_last;
                    if (!dump_last) begin
                        ptr_next = (op_reg == OP_DUMP_FWD) ? rd_nxt : rd_prv;
                        rd_addr  = (op_reg == OP_DUMP_FWD) ? rd_nxt : rd_prv;
                        idx_next = idx_inc;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_vv_next     = res_valid_reg;
                    out_last_next   = 1'b1;
                end
            end
            default: ;
        endcase

        // Unlink the node at ptr and push its slot onto the free stack
        if (do_unlink) begin
            if (count_reg <= CW'(1)) begin
                head_next = '0;
                tail_next = '0;
            end else if (ptr_reg == head_reg) begin
                head_next = rd_nxt;
            end else if (ptr_reg == tail_reg) begin
                tail_next = rd_prv;
            end else begin
                wr_en.nxt = 1'b1;
                nxt_waddr = rd_prv;
                nxt_wdata = rd_nxt;
                wr_en.prv = 1'b1;
                prv_waddr = rd_nxt;
                prv_wdata = rd_prv;
            end
            count_next   = count_reg - 1'b1;
            free_we      = 1'b1;
            fs_head_next = ptr_reg;
        end

        if (out_load) begin
            out_count_next = 6'(count_reg);
        end
        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            hw_reg      <= '0;
            fs_head_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            hw_reg      <= hw_next;
            fs_head_reg <= fs_head_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg         <= op_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_vv_reg     <= out_vv_next;
        out_last_reg   <= out_last_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_value   = out_value_reg;
    assign m_entry_count = out_count_reg;
    assign m_status      = out_status_reg;
    assign m_value_valid = out_vv_reg;
    assign m_last_of_run = out_last_reg;

`ifndef SYNTHESIS
    // list never exceeds its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // fill count covers every live entry
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (hw_reg >= count_reg) && (hw_reg <= CW'(CAPACITY)))
        else $error("fill count out of range");

    // full status only reported with a full list
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_status_reg == ST_FULL) |-> out_count_reg == 6'(CAPACITY))
        else $error("full reported on a list that is not full");

    // a walk index stays inside the list
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH || state_reg == S_DUMP) |-> idx_reg < count_reg)
        else $error("walk ran past the entry count");
`endif

endmodule
